[hdl/lru_block_cache_mapper_defines.svh]
// Assertion helpers for the mapper's top module.
`ifndef LRU_BLOCK_CACHE_MAPPER_DEFINES_SVH
`define LRU_BLOCK_CACHE_MAPPER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LBCM_ASSERT_IMP(name, clk_i, rstn_i, ante, cons, msg) \
    name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LBCM_ASSERT_NXT(name, clk_i, rstn_i, ante, cons, msg) \
    name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/lbcm_pkg.sv]
package lbcm_pkg;

    localparam int unsigned BLOCK_BYTES_DEF = 512 * 1024;
    localparam int unsigned MAX_BLOCKS_DEF  = 128;
    localparam int unsigned CACHE_SLOTS_DEF = 64;

    localparam longint ADDR_SPACE = 64 * 1024 * 1024;

    localparam int ADDR_W      = 26;
    localparam int LEN_W       = 24;
    localparam int CFG_W       = 8;
    localparam int SLOT_W      = 6;
    localparam int OFS_W       = 19;
    localparam int SPAN_W      = 20;
    localparam int ROM_BLK_W   = 7;
    localparam int MAP_W       = 7;
    localparam int AGE_W       = 32;
    localparam int STAMP_W     = 48;
    localparam int MAX_SPANS   = 33;
    localparam int SPAN_CNT_W  = 6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPAN,
        ST_LOOKUP,
        ST_SCAN,
        ST_DRAIN,
        ST_PICK,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [ROM_BLK_W-1:0] blk;
        logic [OFS_W-1:0]     block_offset;
        logic [SPAN_W-1:0]    span_bytes;
        logic                 last;
    } span_info_t;

    typedef struct packed {
        logic                 rd_en;
        logic [ROM_BLK_W-1:0] rd_addr;
        logic                 wr_en;
        logic [ROM_BLK_W-1:0] wr_addr;
        logic [MAP_W-1:0]     wr_slot;
        logic [STAMP_W-1:0]   wr_stamp;
        logic                 clr_en;
        logic [ROM_BLK_W-1:0] clr_addr;
    } store_cmd_t;

    typedef struct packed {
        logic                 valid;
        logic [MAP_W-1:0]     slot;
        logic [STAMP_W-1:0]   stamp;
    } store_rsp_t;

endpackage

[hdl/lbcm_if.sv]
interface lbcm_req_if;
    logic                          valid;
    logic                          ready;
    logic [lbcm_pkg::ADDR_W-1:0]   byte_offset;
    logic [lbcm_pkg::LEN_W-1:0]    byte_length;

    modport source (output valid, output byte_offset, output byte_length, input ready);
    modport sink   (input valid, input byte_offset, input byte_length, output ready);
endinterface

interface lbcm_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [lbcm_pkg::SLOT_W-1:0]   slot;
    logic [lbcm_pkg::OFS_W-1:0]    block_offset;
    logic [lbcm_pkg::SPAN_W-1:0]   span_bytes;
    logic [lbcm_pkg::ROM_BLK_W-1:0] rom_block;
    logic                          load_needed;
    logic                          last;

    modport source (output valid, output slot, output block_offset, output span_bytes,
                    output rom_block, output load_needed, output last, input ready);
    modport sink   (input valid, input slot, input block_offset, input span_bytes,
                    input rom_block, input load_needed, input last, output ready);
endinterface

interface lbcm_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [lbcm_pkg::CFG_W-1:0]    rom_blocks;

    modport source (output valid, output rom_blocks, input ready);
    modport sink   (input valid, input rom_blocks, output ready);
endinterface

[hdl/lru_block_cache_mapper.sv]
// Splits each read request into block-aligned spans and maps every span to a cache slot,
// one response per span (at most 33; the last carries last = 1). Block size must be a power
// of two. With rom_blocks at most CACHE_SLOTS block n sits in slot n. Otherwise slot map and
// age stamps live in one table of MAX_BLOCKS entries with one read and one write port; a miss
// reads every entry through the read port to find the oldest resident block. Ages are kept
// as stamps against a 48-bit span counter, so no clearing pass follows reset. One request
// is worked on at a time; the next is taken while the final response still waits.
`include "lru_block_cache_mapper_defines.svh"

module lru_block_cache_mapper #(
    parameter int unsigned BLOCK_BYTES = lbcm_pkg::BLOCK_BYTES_DEF,
    parameter int unsigned MAX_BLOCKS  = lbcm_pkg::MAX_BLOCKS_DEF,
    parameter int unsigned CACHE_SLOTS = lbcm_pkg::CACHE_SLOTS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    lbcm_req_if.sink      req,
    lbcm_rsp_if.source    rsp,
    lbcm_cfg_if.sink      cfg
);
    import lbcm_pkg::*;

    localparam int BLK_W = $clog2(MAX_BLOCKS);

    state_t                state_reg, state_next;
    logic [CFG_W-1:0]      rom_blocks_reg;
    logic [STAMP_W-1:0]    g_reg, g_next;
    logic [BLK_W-1:0]      scan_idx_reg, scan_idx_next;
    logic                  cmp_vld_reg, cmp_vld_next;
    logic [BLK_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic [AGE_W-1:0]      best_age_reg, best_age_next;
    logic [BLK_W-1:0]      best_idx_reg, best_idx_next;
    logic [MAP_W-1:0]      best_slot_reg, best_slot_next;
    logic [MAP_W-1:0]      res_slot_reg, res_slot_next;
    logic                  res_load_reg, res_load_next;

    logic                  out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]     out_slot_reg;
    logic [OFS_W-1:0]      out_ofs_reg;
    logic [SPAN_W-1:0]     out_span_reg;
    logic [ROM_BLK_W-1:0]  out_blk_reg;
    logic                  out_load_reg;
    logic                  out_last_reg;

    logic                  lru_mode;
    logic                  sg_start;
    logic                  sg_advance;
    logic                  req_empty;
    span_info_t            span;
    store_cmd_t            st_cmd;
    store_rsp_t            st_rsp;
    logic [STAMP_W-1:0]    stamp_diff;
    logic [AGE_W-1:0]      cand_age;
    logic                  out_load;

    assign lru_mode  = {1'b0, rom_blocks_reg} > (CFG_W + 1)'(CACHE_SLOTS);
    assign cfg.ready = 1'b1;

    lbcm_span_gen #(
        .BLOCK_BYTES (BLOCK_BYTES),
        .MAX_BLOCKS  (MAX_BLOCKS)
    ) u_span_gen (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (sg_start),
        .advance   (sg_advance),
        .in_offset (req.byte_offset),
        .in_length (req.byte_length),
        .req_empty (req_empty),
        .span      (span)
    );

    lbcm_tag_store #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .CACHE_SLOTS (CACHE_SLOTS)
    ) u_tag_store (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (st_cmd),
        .rsp   (st_rsp)
    );

    always_comb
    begin
        stamp_diff = g_reg - st_rsp.stamp;
        cand_age   = (|stamp_diff[STAMP_W-1:AGE_W]) ? '1 : stamp_diff[AGE_W-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        g_next         = g_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_vld_next   = 1'b0;
        cmp_idx_next   = scan_idx_reg;
        best_age_next  = best_age_reg;
        best_idx_next  = best_idx_reg;
        best_slot_next = best_slot_reg;
        res_slot_next  = res_slot_reg;
        res_load_next  = res_load_reg;
        sg_start       = 1'b0;
        sg_advance     = 1'b0;
        out_load       = 1'b0;
        req.ready      = 1'b0;
        st_cmd         = '0;

        // fold the previous cycle's read into the running oldest-block choice
        if (cmp_vld_reg)
        begin
            if (cmp_idx_reg == '0)
            begin
                best_slot_next = st_rsp.slot;
            end
            if (st_rsp.valid && (cand_age > best_age_reg))
            begin
                best_age_next  = cand_age;
                best_idx_next  = cmp_idx_reg;
                best_slot_next = st_rsp.slot;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid && !req_empty)
                begin
                    sg_start   = 1'b1;
                    state_next = ST_SPAN;
                end
            end
            ST_SPAN:
            begin
                if (lru_mode)
                begin
                    st_cmd.rd_en   = 1'b1;
                    st_cmd.rd_addr = span.blk;
                    state_next     = ST_LOOKUP;
                end
                else
                begin
                    res_slot_next = MAP_W'(span.blk);
                    res_load_next = 1'b0;
                    state_next    = ST_EMIT;
                end
            end
            ST_LOOKUP:
            begin
                if (st_rsp.valid)
                begin
                    st_cmd.wr_en    = 1'b1;
                    st_cmd.wr_addr  = span.blk;
                    st_cmd.wr_slot  = st_rsp.slot;
                    st_cmd.wr_stamp = g_reg + STAMP_W'(1);
                    g_next          = g_reg + STAMP_W'(1);
                    res_slot_next   = st_rsp.slot;
                    res_load_next   = 1'b0;
                    state_next      = ST_EMIT;
                end
                else
                begin
                    scan_idx_next = '0;
                    best_age_next = '0;
                    best_idx_next = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                st_cmd.rd_en   = 1'b1;
                st_cmd.rd_addr = ROM_BLK_W'(scan_idx_reg);
                cmp_vld_next   = 1'b1;
                if (scan_idx_reg == BLK_W'(MAX_BLOCKS - 1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + BLK_W'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_PICK;
            end
            ST_PICK:
            begin
                st_cmd.clr_en   = 1'b1;
                st_cmd.clr_addr = ROM_BLK_W'(best_idx_reg);
                st_cmd.wr_en    = 1'b1;
                st_cmd.wr_addr  = span.blk;
                st_cmd.wr_slot  = best_slot_reg;
                st_cmd.wr_stamp = g_reg + STAMP_W'(1);
                g_next          = g_reg + STAMP_W'(1);
                res_slot_next   = best_slot_reg;
                res_load_next   = 1'b1;
                state_next      = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load = 1'b1;
                    if (span.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        sg_advance = 1'b1;
                        state_next = ST_SPAN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rom_blocks_reg <= '0;
            g_reg          <= STAMP_W'(MAX_BLOCKS - 1);
            scan_idx_reg   <= '0;
            cmp_vld_reg    <= 1'b0;
            cmp_idx_reg    <= '0;
            best_age_reg   <= '0;
            best_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            g_reg         <= g_next;
            scan_idx_reg  <= scan_idx_next;
            cmp_vld_reg   <= cmp_vld_next;
            cmp_idx_reg   <= cmp_idx_next;
            best_age_reg  <= best_age_next;
            best_idx_reg  <= best_idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                rom_blocks_reg <= cfg.rom_blocks;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        best_slot_reg <= best_slot_next;
        res_slot_reg  <= res_slot_next;
        res_load_reg  <= res_load_next;
        if (out_load)
        begin
            out_slot_reg <= SLOT_W'(res_slot_reg);
            out_ofs_reg  <= span.block_offset;
            out_span_reg <= span.span_bytes;
            out_blk_reg  <= span.blk;
            out_load_reg <= res_load_reg;
            out_last_reg <= span.last;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.slot         = out_slot_reg;
    assign rsp.block_offset = out_ofs_reg;
    assign rsp.span_bytes   = out_span_reg;
    assign rsp.rom_block    = out_blk_reg;
    assign rsp.load_needed  = out_load_reg;
    assign rsp.last         = out_last_reg;

    `LBCM_ASSERT_IMP(a_scan_only_lru, clk, rst_n, state_reg == ST_SCAN, lru_mode,
        "victim scan outside LRU mode")
    `LBCM_ASSERT_IMP(a_load_only_lru, clk, rst_n, rsp.valid && rsp.load_needed, lru_mode,
        "load request outside LRU mode")
    `LBCM_ASSERT_IMP(a_direct_slot, clk, rst_n, rsp.valid && !lru_mode,
        rsp.slot == SLOT_W'(rsp.rom_block), "direct mode slot differs from block")
    `LBCM_ASSERT_NXT(a_stamp_step, clk, rst_n, st_cmd.wr_en,
        g_reg == $past(g_reg) + STAMP_W'(1), "span counter did not advance on update")

endmodule

[hdl/lbcm_span_gen.sv]
module lbcm_span_gen #(
    parameter int unsigned BLOCK_BYTES = lbcm_pkg::BLOCK_BYTES_DEF,
    parameter int unsigned MAX_BLOCKS  = lbcm_pkg::MAX_BLOCKS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          advance,
    input  logic [lbcm_pkg::ADDR_W-1:0]   in_offset,
    input  logic [lbcm_pkg::LEN_W-1:0]    in_length,
    output logic                          req_empty,
    output lbcm_pkg::span_info_t          span
);
    import lbcm_pkg::*;

    localparam int     POS_W       = ADDR_W + 1;
    localparam int     BLK_ADDR_LSB = $clog2(BLOCK_BYTES);
    localparam int     BLK_W       = $clog2(MAX_BLOCKS);
    localparam longint ROM_END     = longint'(MAX_BLOCKS) * longint'(BLOCK_BYTES);
    localparam longint LIM_WIDE    = (ROM_END < ADDR_SPACE) ? ROM_END : ADDR_SPACE;
    localparam logic [POS_W-1:0] LIM       = POS_W'(LIM_WIDE);
    localparam logic [POS_W-1:0] BLK_BYTES = POS_W'(BLOCK_BYTES);

    logic [POS_W-1:0]      off_reg, off_next;
    logic [POS_W-1:0]      end_reg, end_next;
    logic [SPAN_CNT_W-1:0] cnt_reg, cnt_next;

    logic [POS_W-1:0]      req_end;
    logic [POS_W-1:0]      in_block;
    logic [POS_W-1:0]      to_blk_end;
    logic [POS_W-1:0]      remain;
    logic [POS_W-1:0]      span_len;
    logic [POS_W-1:0]      blk_wide;
    logic [BLK_W-1:0]      blk;

    always_comb
    begin
        req_end   = POS_W'(in_offset) + POS_W'(in_length);
        if (req_end > LIM)
        begin
            req_end = LIM;
        end
        req_empty = (in_length == '0) || (POS_W'(in_offset) >= LIM);

        in_block   = off_reg & (BLK_BYTES - POS_W'(1));
        to_blk_end = BLK_BYTES - in_block;
        remain     = end_reg - off_reg;
        span_len   = (remain < to_blk_end) ? remain : to_blk_end;
        blk_wide   = off_reg >> BLK_ADDR_LSB;
        blk        = blk_wide[BLK_W-1:0];

        span.blk          = ROM_BLK_W'(blk);
        span.block_offset = OFS_W'(in_block);
        span.span_bytes   = SPAN_W'(span_len);
        span.last         = (remain <= to_blk_end)
                            || (cnt_reg == SPAN_CNT_W'(MAX_SPANS - 1));

        off_next = off_reg;
        end_next = end_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            off_next = POS_W'(in_offset);
            end_next = req_end;
            cnt_next = '0;
        end
        else if (advance)
        begin
            off_next = off_reg + span_len;
            cnt_next = cnt_reg + SPAN_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg <= '0;
            end_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            off_reg <= off_next;
            end_reg <= end_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

[hdl/lbcm_tag_store.sv]
module lbcm_tag_store #(
    parameter int unsigned MAX_BLOCKS  = lbcm_pkg::MAX_BLOCKS_DEF,
    parameter int unsigned CACHE_SLOTS = lbcm_pkg::CACHE_SLOTS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lbcm_pkg::store_cmd_t  cmd,
    output lbcm_pkg::store_rsp_t  rsp
);
    import lbcm_pkg::*;

    localparam int BLK_W   = $clog2(MAX_BLOCKS);
    localparam int ENTRY_W = MAP_W + STAMP_W;

    logic [ENTRY_W-1:0] mem_ram [MAX_BLOCKS];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [BLK_W-1:0]   rd_addr_reg;
    logic               rd_touched_reg;
    logic               rd_valid_reg;
    logic               valid_reg   [MAX_BLOCKS];
    logic               touched_reg [MAX_BLOCKS];

    logic [BLK_W-1:0]   ra;
    logic [BLK_W-1:0]   wa;
    logic [BLK_W-1:0]   ca;

    assign ra = cmd.rd_addr[BLK_W-1:0];
    assign wa = cmd.wr_addr[BLK_W-1:0];
    assign ca = cmd.clr_addr[BLK_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem_ram[wa] <= {cmd.wr_slot, cmd.wr_stamp};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem_ram[ra];
            rd_addr_reg <= ra;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_touched_reg <= 1'b0;
            rd_valid_reg   <= 1'b0;
            for (int i = 0; i < MAX_BLOCKS; i++)
            begin
                valid_reg[i]   <= (i < CACHE_SLOTS);
                touched_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cmd.rd_en)
            begin
                rd_touched_reg <= touched_reg[ra];
                rd_valid_reg   <= valid_reg[ra];
            end
            // drop the victim first so that a refill of the same block stays valid
            if (cmd.clr_en)
            begin
                valid_reg[ca] <= 1'b0;
            end
            if (cmd.wr_en)
            begin
                valid_reg[wa]   <= 1'b1;
                touched_reg[wa] <= 1'b1;
            end
        end
    end

    always_comb
    begin
        rsp.valid = rd_valid_reg;
        if (rd_touched_reg)
        begin
            rsp.slot  = rd_data_reg[ENTRY_W-1:STAMP_W];
            rsp.stamp = rd_data_reg[STAMP_W-1:0];
        end
        else
        begin
            rsp.slot  = MAP_W'(rd_addr_reg);
            rsp.stamp = STAMP_W'(MAX_BLOCKS - 1) - STAMP_W'(rd_addr_reg);
        end
    end

endmodule

[sim/lbcm_span_checker.sv]
`timescale 1ns / 100ps

module lbcm_span_checker
    import lbcm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    lbcm_req_if  req,
    lbcm_rsp_if  rsp,
    lbcm_cfg_if  cfg,
    output int   fail_count,
    output int   outstanding,
    output int   request_count,
    output int   span_count,
    output int   load_count
);

    localparam longint ROM_SPACE = longint'(MAX_BLOCKS_DEF) * longint'(BLOCK_BYTES_DEF);
    localparam longint END_LIMIT = (ROM_SPACE < ADDR_SPACE) ? ROM_SPACE : ADDR_SPACE;

    typedef struct packed {
        logic [SLOT_W-1:0]    slot;
        logic [OFS_W-1:0]     block_offset;
        logic [SPAN_W-1:0]    span_bytes;
        logic [ROM_BLK_W-1:0] rom_block;
        logic                 load_needed;
        logic                 last;
    } span_rec_t;

    logic [CFG_W-1:0] rom_blocks_cfg;
    logic             resident [MAX_BLOCKS_DEF];
    logic [MAP_W-1:0] slot_of  [MAX_BLOCKS_DEF];
    logic [AGE_W-1:0] age      [MAX_BLOCKS_DEF];
    span_rec_t        expected_spans [$];

    task automatic clear_cache_state();
        rom_blocks_cfg = '0;
        for (int i = 0; i < MAX_BLOCKS_DEF; i++)
        begin
            resident[i] = (i < CACHE_SLOTS_DEF);
            slot_of[i]  = MAP_W'(i);
            age[i]      = AGE_W'(i);
        end
        expected_spans.delete();
        fail_count    = 0;
        outstanding   = 0;
        request_count = 0;
        span_count    = 0;
        load_count    = 0;
    endtask

    function automatic int oldest_resident();
        int               best;
        logic [AGE_W-1:0] best_age;
        best     = 0;
        best_age = '0;
        for (int i = 0; i < MAX_BLOCKS_DEF; i++)
        begin
            if (resident[i] && age[i] > best_age)
            begin
                best     = i;
                best_age = age[i];
            end
        end
        return best;
    endfunction

    task automatic map_request(input logic [ADDR_W-1:0] off_in, input logic [LEN_W-1:0] len_in);
        longint    cur;
        longint    stop;
        longint    inb;
        longint    span;
        int        blk;
        int        victim;
        int        n;
        logic      lru;
        span_rec_t s;
        cur = longint'(off_in);
        if (len_in == 0 || cur >= END_LIMIT)
            return;
        stop = cur + longint'(len_in);
        if (stop > END_LIMIT)
            stop = END_LIMIT;
        lru = (rom_blocks_cfg > CACHE_SLOTS_DEF);
        n   = 0;
        while (cur < stop && n < MAX_SPANS)
        begin
            blk = int'(cur / longint'(BLOCK_BYTES_DEF));
            if (blk > MAX_BLOCKS_DEF - 1)
                blk = MAX_BLOCKS_DEF - 1;
            inb  = cur % longint'(BLOCK_BYTES_DEF);
            span = longint'(BLOCK_BYTES_DEF) - inb;
            if (span > stop - cur)
                span = stop - cur;
            s.load_needed = 1'b0;
            if (lru)
            begin
                if (!resident[blk])
                begin
                    // evict before claiming, so the victim's slot passes to the new block
                    victim           = oldest_resident();
                    resident[victim] = 1'b0;
                    slot_of[blk]     = slot_of[victim];
                    resident[blk]    = 1'b1;
                    s.load_needed    = 1'b1;
                end
                for (int i = 0; i < MAX_BLOCKS_DEF; i++)
                begin
                    if (age[i] != '1)
                        age[i] = age[i] + 1'b1;
                end
                age[blk] = '0;
                s.slot   = SLOT_W'(slot_of[blk]);
            end
            else
            begin
                s.slot = SLOT_W'(blk);
            end
            cur            = cur + span;
            s.block_offset = OFS_W'(inb);
            s.span_bytes   = SPAN_W'(span);
            s.rom_block    = ROM_BLK_W'(blk);
            s.last         = (cur >= stop) || (n + 1 == MAX_SPANS);
            expected_spans.push_back(s);
            n++;
        end
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        span_rec_t want;
        if (!rst_n)
        begin
            clear_cache_state();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                rom_blocks_cfg = cfg.rom_blocks;
            if (req.valid && req.ready)
            begin
                request_count++;
                map_request(req.byte_offset, req.byte_length);
            end
            if (rsp.valid && rsp.ready)
            begin
                if (expected_spans.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: span with no request open, expected none, actual block %0d slot %0d",
                             $time, rsp.rom_block, rsp.slot);
                end
                else
                begin
                    want = expected_spans.pop_front();
                    check_field("slot", want.slot, rsp.slot);
                    check_field("block_offset", want.block_offset, rsp.block_offset);
                    check_field("span_bytes", want.span_bytes, rsp.span_bytes);
                    check_field("rom_block", want.rom_block, rsp.rom_block);
                    check_field("load_needed", want.load_needed, rsp.load_needed);
                    check_field("last", want.last, rsp.last);
                    span_count++;
                    if (rsp.load_needed)
                        load_count++;
                end
            end
            outstanding = expected_spans.size();
        end
    end

endmodule

[sim/tb_lru_block_cache_mapper.sv]
`timescale 1ns / 100ps

module tb_lru_block_cache_mapper;
    import lbcm_pkg::*;

    localparam int unsigned LIMIT_CYCLES  = 6_000_000;
    localparam int          SETTLE_CYCLES = 300;
    localparam int          HOLD_CYCLES   = 600;
    localparam int unsigned BLK           = BLOCK_BYTES_DEF;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        tx_quiet = 1'b0;
    logic        rx_quiet = 1'b0;
    logic        rx_hold  = 1'b0;
    logic        hold_go  = 1'b0;
    int unsigned cycle_count = 0;
    int          fail_count;
    int          outstanding;
    int          request_count;
    int          span_count;
    int          load_count;
    logic [ROM_BLK_W-1:0] hot [8];

    lbcm_req_if req_ch();
    lbcm_rsp_if rsp_ch();
    lbcm_cfg_if cfg_ch();

    lru_block_cache_mapper dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    lbcm_span_checker span_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .cfg           (cfg_ch),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .request_count (request_count),
        .span_count    (span_count),
        .load_count    (load_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // hold the response side off for a long stretch
    initial
    begin
        wait (hold_go);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
    end

    initial
    begin
        int pause;
        rsp_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            pause = rx_quiet ? 0 : $urandom_range(0, 7);
            if (pause > 0 || rx_hold)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (pause) @(posedge clk);
                while (rx_hold) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
        end
    end

    task automatic send_request(input logic [ADDR_W-1:0] off, input logic [LEN_W-1:0] len);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.byte_offset <= off;
        req_ch.byte_length <= len;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_rom_blocks(input logic [CFG_W-1:0] value);
        settle();
        cfg_ch.valid      <= 1'b1;
        cfg_ch.rom_blocks <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // mostly reads around a drifting set of hot blocks, with some scattered and empty requests
    task automatic send_random(input int count);
        int                sent;
        int                pick;
        logic [ADDR_W-1:0] off;
        logic [LEN_W-1:0]  len;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 19);
            if ($urandom_range(0, 15) == 0)
                hot[$urandom_range(0, 7)] = ROM_BLK_W'($urandom);
            off = ADDR_W'($urandom);
            if (pick == 0)
                len = '0;
            else if (pick == 1)
                len = LEN_W'($urandom);
            else
            begin
                if (pick < 13)
                    off = {hot[$urandom_range(0, 7)], OFS_W'($urandom)};
                case ($urandom_range(0, 3))
                    0:       len = LEN_W'($urandom_range(1, 16));
                    1:       len = LEN_W'($urandom_range(1, 4096));
                    2:       len = LEN_W'($urandom_range(1, BLK));
                    default: len = LEN_W'($urandom_range(BLK, 3 * BLK));
                endcase
            end
            send_request(off, len);
            if (len != 0)
                sent++;
        end
    endtask

    initial
    begin
        req_ch.valid       <= 1'b0;
        req_ch.byte_offset <= '0;
        req_ch.byte_length <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.rom_blocks  <= '0;
        for (int i = 0; i < 8; i++)
            hot[i] = ROM_BLK_W'($urandom);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        write_rom_blocks(8'd0);
        send_request(26'd0, 24'd1);
        send_request(26'd0, 24'd0);
        send_request('1, '1);
        send_request(ADDR_W'(BLK - 1), 24'd2);
        send_request(26'h123, '1);
        send_request(ADDR_W'(ADDR_SPACE - BLK), LEN_W'(BLK));
        send_request(ADDR_W'(ADDR_SPACE - 100), 24'd1000);
        send_request(ADDR_W'(100 * BLK + 7), 24'd64);

        write_rom_blocks(CFG_W'(CACHE_SLOTS_DEF));
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        send_request(ADDR_W'(63 * BLK), 24'd16);
        send_request(ADDR_W'(64 * BLK + 5), 24'd16);
        send_random(40);

        write_rom_blocks(CFG_W'(CACHE_SLOTS_DEF + 1));
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        send_request(ADDR_W'(64 * BLK), 24'd1);
        send_request(ADDR_W'(0), 24'd8);
        send_request(ADDR_W'(64 * BLK + 3), 24'd8);
        send_request(ADDR_W'(127 * BLK), LEN_W'(BLK));
        send_request(ADDR_W'(63 * BLK + BLK - 1), 24'd1);
        send_request(ADDR_W'(70 * BLK + 9), LEN_W'(2 * BLK));
        send_request(ADDR_W'(90 * BLK + 1), '1);
        send_request('1, '1);
        send_random(100);

        write_rom_blocks(8'd255);
        tx_quiet = 1'b1;
        send_random(70);

        write_rom_blocks(8'd10);
        tx_quiet = 1'b0;
        rx_quiet = 1'b1;
        send_random(40);

        write_rom_blocks(CFG_W'(MAX_BLOCKS_DEF));
        tx_quiet = 1'b1;
        hold_go  = 1'b1;
        send_random(20);
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        send_random(30);

        settle();
        $display("Mapped %0d requests into %0d spans with %0d block loads,", request_count,
                 span_count, load_count);
        $display("over direct and LRU settings 0, 64, 65, 255, 10 and 128.");
        if (fail_count == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/lbcm_pkg.sv
hdl/lbcm_if.sv
hdl/lbcm_span_gen.sv
hdl/lbcm_tag_store.sv
hdl/lru_block_cache_mapper.sv
sim/lbcm_span_checker.sv
sim/tb_lru_block_cache_mapper.sv
